FILE: hdl/frame_min_max_mean_assert.svh
// assertion macros shared by the frame statistics modules
// depends on nothing; included by fmm_queue and fmm_back
`ifndef FRAME_MIN_MAX_MEAN_ASSERT_SVH
`define FRAME_MIN_MAX_MEAN_ASSERT_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define FMM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define FMM_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FMM_ASSERT(lbl, clk, rst, prop, msg)
`define FMM_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: hdl/fmm_pkg.sv
// constants and types for the frame min/max/mean statistics block
// depends on nothing; used by every module of the block
package fmm_pkg;

  localparam int PIXEL_BITS    = 16;
  localparam int COUNT_BITS    = 24;
  localparam int SUM_BITS      = COUNT_BITS + PIXEL_BITS;
  localparam int IN_DATA_BITS  = 16;
  localparam int PIX_FIELD     = 16;
  localparam int TOTAL_FIELD   = 24;
  localparam int OUT_DATA_BITS = 80;
  localparam int STEP_BITS     = $clog2(PIXEL_BITS);

  // closed-frame accumulators handed from front to back
  typedef struct packed {
    logic [PIXEL_BITS-1:0] min_v;
    logic [PIXEL_BITS-1:0] max_v;
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic                  ovf;
  } frame_stats_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

FILE: hdl/fmm_front.sv
// front part: accepts pixel items and keeps the running accumulators
// depends on fmm_pkg; pushes one frame_stats_t per frame end
module fmm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fmm_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  fmm_pkg::queue_status_t            q_status,
  output logic                              push,
  output fmm_pkg::frame_stats_t             push_data
);
  import fmm_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [PIXEL_BITS-1:0] run_min, run_min_next;
  logic [PIXEL_BITS-1:0] run_max, run_max_next;
  logic [SUM_BITS-1:0]   sum, sum_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic                  ovf, ovf_next;
  logic [PIXEL_BITS-1:0] pix;
  logic                  take;

  assign pix           = s_axis_tdata[PIXEL_BITS-1:0];
  assign s_axis_tready = !q_status.full;
  assign take          = s_axis_tvalid && s_axis_tready;

  // accumulator update for one item
  always_comb begin
    run_min_next = run_min;
    run_max_next = run_max;
    sum_next     = sum;
    count_next   = count;
    ovf_next     = ovf;
    if (s_axis_tuser) begin
      if (pix < run_min) run_min_next = pix;
      if (pix > run_max) run_max_next = pix;
      if (count == CNT_MAX) begin
        ovf_next = 1'b1;
      end else begin
        sum_next   = sum + SUM_BITS'(pix);
        count_next = count + 1'b1;
      end
    end
  end

  // snapshot of the frame including the closing pixel
  assign push = take && s_axis_tlast;
  assign push_data = '{min_v: run_min_next, max_v: run_max_next, sum: sum_next,
                       count: count_next, ovf: ovf_next};

  // accumulators, cleared at reset and at every frame end
  always_ff @(posedge clk) begin
    if (rst || push) begin
      run_min <= {PIXEL_BITS{1'b1}};
      run_max <= '0;
      sum     <= '0;
      count   <= '0;
      ovf     <= 1'b0;
    end else if (take) begin
      run_min <= run_min_next;
      run_max <= run_max_next;
      sum     <= sum_next;
      count   <= count_next;
      ovf     <= ovf_next;
    end
  end

endmodule

FILE: hdl/fmm_queue.sv
// two-entry queue of closed-frame accumulators between front and back
// depends on fmm_pkg and frame_min_max_mean_assert.svh
`include "frame_min_max_mean_assert.svh"
module fmm_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fmm_pkg::frame_stats_t  push_data,
  input  logic                   pop,
  output fmm_pkg::frame_stats_t  pop_data,
  output fmm_pkg::queue_status_t status
);
  import fmm_pkg::*;

  frame_stats_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   level;

  assign status.full      = (level == 2'd2);
  assign status.not_empty = (level != 2'd0);
  assign pop_data         = entry[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      level <= level + 2'd1;
      else if (pop && !push) level <= level - 2'd1;
    end
  end

  `FMM_NEVER(a_push_full, clk, rst, push && status.full, "push into full queue")
  `FMM_NEVER(a_pop_empty, clk, rst, pop && !status.not_empty, "pop from empty queue")
  `FMM_NEVER(a_level_range, clk, rst, level == 2'd3, "queue level out of range")

endmodule

FILE: hdl/fmm_back.sv
// back part: divides sum by count one quotient bit per cycle and holds the result
// depends on fmm_pkg and frame_min_max_mean_assert.svh
`include "frame_min_max_mean_assert.svh"
module fmm_back (
  input  logic                               clk,
  input  logic                               rst,
  input  fmm_pkg::queue_status_t             q_status,
  input  fmm_pkg::frame_stats_t              pop_data,
  output logic                               pop,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [fmm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
  import fmm_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DIV,
    OUT
  } state_t;

  state_t                state;
  logic [PIXEL_BITS-1:0] res_min;
  logic [PIXEL_BITS-1:0] res_max;
  logic [COUNT_BITS-1:0] divisor;
  logic                  res_ovf;
  logic [COUNT_BITS-1:0] rem;
  logic [PIXEL_BITS-1:0] quo;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic [COUNT_BITS:0]   diff;

  assign pop = (state == IDLE) && q_status.not_empty;

  // one restoring division step
  always_comb begin
    trial = {rem, quo[PIXEL_BITS-1]};
    fits  = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  // sequencer, divider registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (pop) begin
            divisor <= pop_data.count;
            step    <= STEP_BITS'(PIXEL_BITS - 1);
            if (pop_data.count == '0) begin
              res_min <= '0;
              res_max <= '0;
              res_ovf <= 1'b0;
              quo     <= '0;
              state   <= OUT;
            end else begin
              res_min <= pop_data.min_v;
              res_max <= pop_data.max_v;
              res_ovf <= pop_data.ovf;
              rem     <= pop_data.sum[SUM_BITS-1:PIXEL_BITS];
              quo     <= pop_data.sum[PIXEL_BITS-1:0];
              state   <= DIV;
            end
          end
        end
        DIV: begin
          rem  <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
          quo  <= {quo[PIXEL_BITS-2:0], fits};
          step <= step - 1'b1;
          if (step == '0) state <= OUT;
        end
        OUT: begin
          if (m_axis_tready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state == OUT);
  assign m_axis_tdata  = {{(OUT_DATA_BITS - 3*PIX_FIELD - TOTAL_FIELD - 1){1'b0}},
                          res_ovf, TOTAL_FIELD'(divisor), PIX_FIELD'(quo),
                          PIX_FIELD'(res_max), PIX_FIELD'(res_min)};

  `FMM_ASSERT(a_rem_below, clk, rst, (state == DIV) |-> (rem < divisor),
              "partial remainder not below divisor")
  `FMM_ASSERT(a_empty_zero, clk, rst,
              (m_axis_tvalid && divisor == '0) |->
              (res_min == '0 && res_max == '0 && quo == '0 && !res_ovf),
              "empty frame result not all zero")
  `FMM_ASSERT(a_min_le_max, clk, rst,
              (m_axis_tvalid && divisor != '0) |-> (res_min <= res_max),
              "frame minimum above maximum")

endmodule

FILE: hdl/frame_min_max_mean.sv
// top level of the per-frame pixel min/max/mean statistics block
// depends on fmm_pkg, fmm_front, fmm_queue and fmm_back
//
//  channel  | dir | tdata                               | tuser     | tlast
//  s_axis   | in  | pixel[15:0]                         | has_pixel | frame_end
//  m_axis   | out | min, max, mean, total[23:0], ovf    | -         | -
//
// pixels are taken one per cycle unless the queue is full; a frame end may ride on the last pixel
// each frame result is loaded from the queue, run through the shift-subtract divider
// and then presented until taken; empty frames skip the divider
// a two-entry queue holds closed frames, so input stalls only with two pending
// rst is synchronous, active high, and clears accumulators, queue and sequencer
module frame_min_max_mean (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] pixel
  input  logic [fmm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // [0] has_pixel
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] min_value, [31:16] max_value, [47:32] mean_value,
  // [71:48] pixel_total, [72] count_overflow, [79:73] zero
  output logic [fmm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
  import fmm_pkg::*;

  queue_status_t q_status;
  logic          push;
  logic          pop;
  frame_stats_t  push_data;
  frame_stats_t  pop_data;

  // accumulate pixels and close frames
  fmm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_status      (q_status),
    .push          (push),
    .push_data     (push_data)
  );

  // closed frames waiting for the divider
  fmm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // mean division and result output
  fmm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .pop_data      (pop_data),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: sim/tb_frame_min_max_mean.sv
// testbench for frame_min_max_mean: pixel streams in, per-frame min/max/mean/count out
// depends on fmm_pkg and frame_min_max_mean; needs no files or arguments
// a running-statistics predictor computes each frame result, which is checked field by field
module tb_frame_min_max_mean;
  timeunit 1ns;
  timeprecision 1ps;

  import fmm_pkg::*;

  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 40;

  // one expected frame result
  typedef struct packed {
    logic [15:0] min_v;
    logic [15:0] max_v;
    logic [15:0] mean_v;
    logic [23:0] total;
    logic        ovf;
  } frame_result_t;

  // running frame statistics and the frame results still owed by the block
  class frame_stats_board;
    bit [15:0]     lo;
    bit [15:0]     hi;
    bit [39:0]     acc;
    bit [23:0]     cnt;
    bit            ovf;
    frame_result_t pending_stats[$];
    int            errors;
    int            frames_seen;

    function new();
      errors = 0;
      frames_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      lo  = 16'hffff;
      hi  = 16'h0000;
      acc = '0;
      cnt = '0;
      ovf = 1'b0;
    endfunction

    // fold one accepted input item into the running statistics
    function void note_item(bit [15:0] pixel, bit has_pixel, bit frame_end);
      frame_result_t r;
      bit [39:0]     quot;
      if (has_pixel) begin
        if (pixel < lo) lo = pixel;
        if (pixel > hi) hi = pixel;
        // saturated count still tracks min and max, drops the pixel from the mean
        if (cnt == '1) begin
          ovf = 1'b1;
        end else begin
          acc = acc + {24'd0, pixel};
          cnt = cnt + 24'd1;
        end
      end
      if (!frame_end) return;
      if (cnt != '0) begin
        quot     = acc / {16'd0, cnt};
        r.min_v  = lo;
        r.max_v  = hi;
        r.mean_v = quot[15:0];
        r.total  = cnt;
        r.ovf    = ovf;
      end else begin
        // empty frame reports all zeros
        r = '0;
      end
      pending_stats.push_back(r);
      clear_frame();
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    // logic arguments keep unknown bits visible to the compare
    task check_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want)
        report($sformatf("frame %0d %s got %h want %h", frames_seen, name, got, want));
    endtask

    // compare one accepted result with the oldest expected frame
    task check_stats(logic [OUT_DATA_BITS-1:0] data);
      frame_result_t want;
      if (pending_stats.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      want = pending_stats.pop_front();
      check_field("min_value", 24'(data[15:0]), 24'(want.min_v));
      check_field("max_value", 24'(data[31:16]), 24'(want.max_v));
      check_field("mean_value", 24'(data[47:32]), 24'(want.mean_v));
      check_field("pixel_total", data[71:48], want.total);
      check_field("count_overflow", 24'(data[72]), 24'(want.ovf));
      check_field("padding", 24'(data[79:73]), 24'd0);
      frames_seen++;
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     s_axis_tlast = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  frame_stats_board board = new();

  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  int sink_stall = 0;
  int items_sent = 0;

  frame_min_max_mean dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [15:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hffff;
    if (r < 35) return 16'(32'h8000 + $urandom_range(0, 255) - 128);
    return 16'($urandom);
  endfunction

  // drive one item and hold it until accepted; call right after a rising edge
  task automatic send_item(bit [15:0] pixel, bit has_pixel, bit frame_end);
    int gap;
    if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    s_axis_tuser  <= has_pixel;
    s_axis_tlast  <= frame_end;
    do @(posedge clk); while (!s_axis_tready);
    board.note_item(pixel, has_pixel, frame_end);
    if (has_pixel || frame_end) items_sent++;
  endtask

  // random frame: mostly short, a few long, some empty, stray idle items mixed in
  task automatic send_random_frame();
    int r;
    int len;
    bit bare_end;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_item(16'($urandom), 1'b0, 1'b1);
      return;
    end
    len = (r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 48);
    bare_end = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 3) send_item(16'($urandom), 1'b0, 1'b0);
      send_item(pick_pixel(), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end) send_item(16'($urandom), 1'b0, 1'b1);
  endtask

  // result side: accept, check, and stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_stats(m_axis_tdata);
    if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
      sink_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // run limit
  initial begin
    #6_000_000;
    $display("tb_frame_min_max_mean: FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty frame straight after reset, then an idle item
    send_item(16'h0000, 1'b0, 1'b1);
    send_item(16'hffff, 1'b0, 1'b0);
    // single-pixel frames at both extremes
    send_item(16'h0000, 1'b1, 1'b1);
    send_item(16'hffff, 1'b1, 1'b1);
    // both extremes in one frame, closed by a bare end
    send_item(16'hffff, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h0000, 1'b0, 1'b1);
    // idle item inside a frame
    send_item(16'h1234, 1'b1, 1'b0);
    send_item(16'hffff, 1'b0, 1'b0);
    send_item(16'h0010, 1'b1, 1'b1);
    // back-to-back empty frames, ignored pixel bits on the second
    send_item(16'h0000, 1'b0, 1'b1);
    send_item(16'habcd, 1'b0, 1'b1);
    // falling then rising pixels so min and max move on their own
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h4000, 1'b1, 1'b0);
    send_item(16'h0001, 1'b1, 1'b1);
    send_item(16'h0005, 1'b1, 1'b0);
    send_item(16'hfffe, 1'b1, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) send_random_frame();
    s_axis_tvalid <= 1'b0;

    // drain outstanding frames, then watch for strays
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_stats.size() != 0)
      board.report($sformatf("%0d frame results never arrived", board.pending_stats.size()));

    if (board.errors == 0) begin
      $display("tb_frame_min_max_mean: PASS");
    end else begin
      $display("tb_frame_min_max_mean: FAIL");
    end
    $finish;
  end

endmodule
